### rtl/core/mp2_pkg.sv
// ----------------------------------------------------------------------------
// mp2_pkg
// Shared widths, types and matrix entry indexes for the 2x2 matrix power block.
// ----------------------------------------------------------------------------
package mp2_pkg;

   localparam int FIELD_WIDTH        = 32;
   localparam int EXP_WIDTH          = 31;
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int DIGIT_WIDTH        = 4;

   // entry order in a packed matrix: row-major
   localparam int IDX_00 = 0;
   localparam int IDX_01 = 1;
   localparam int IDX_10 = 2;
   localparam int IDX_11 = 3;

   typedef logic signed [FIELD_WIDTH-1:0] field_type;
   typedef logic [EXP_WIDTH-1:0]          exp_type;

endpackage

### rtl/core/matrix_power_2x2.sv
// ----------------------------------------------------------------------------
// matrix_power_2x2
// Raises a 2x2 matrix of 32-bit two's complement integers to a power.
// ----------------------------------------------------------------------------
// The block takes one matrix and exponent per transfer and returns base^exponent
// with every product and sum wrapped modulo 2^DATA_WIDTH; an exponent of zero
// returns the identity. It works by square-and-multiply, one exponent bit per
// step, and stops as soon as the remaining exponent bits are all zero. Each
// step runs the accumulator product and the base square side by side in two
// digit-serial multipliers that take DIGIT_WIDTH (4) bits of the right operand
// per cycle. One item is worked on at a time; the next is taken while the
// previous result still waits in the output register.
// ----------------------------------------------------------------------------
module matrix_power_2x2 #(
   parameter int DATA_WIDTH = mp2_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  mp2_pkg::field_type  req_m00,
   input  mp2_pkg::field_type  req_m01,
   input  mp2_pkg::field_type  req_m10,
   input  mp2_pkg::field_type  req_m11,
   input  mp2_pkg::exp_type    req_exponent,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output mp2_pkg::field_type  rsp_p00,
   output mp2_pkg::field_type  rsp_p01,
   output mp2_pkg::field_type  rsp_p10,
   output mp2_pkg::field_type  rsp_p11
);

   localparam int FW = mp2_pkg::FIELD_WIDTH;

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a request transfer
   localparam logic [1:0] S_STEP = 2'd1;  // check exponent, kick off a step
   localparam logic [1:0] S_WAIT = 2'd2;  // multipliers running
   localparam logic [1:0] S_FIN  = 2'd3;  // hand result to output register

   logic [1:0]                 state_ff, state_in;
   logic [3:0][DATA_WIDTH-1:0] base_ff, base_in;
   logic [3:0][DATA_WIDTH-1:0] acc_ff, acc_in;
   mp2_pkg::exp_type           exp_ff, exp_in;

   logic [3:0][DATA_WIDTH-1:0] mul_c, sq_c;
   logic                       mul_done, sq_done;
   logic                       step_start;

   logic                       rsp_valid_ff, rsp_valid_in;
   mp2_pkg::field_type         p00_ff, p00_in;
   mp2_pkg::field_type         p01_ff, p01_in;
   mp2_pkg::field_type         p10_ff, p10_in;
   mp2_pkg::field_type         p11_ff, p11_in;

   logic                       req_xfer, out_free;

   assign req_xfer   = req_valid && (state_ff == S_IDLE);
   // output register can take a result when empty or being drained this cycle
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign step_start = (state_ff == S_STEP) && (exp_ff != '0);

   // accumulator times base, and base squared, both from the current base
   mp2_matmul #(.DATA_WIDTH(DATA_WIDTH)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (step_start),
      .mat_a (acc_ff),
      .mat_b (base_ff),
      .mat_c (mul_c),
      .done  (mul_done)
   );

   mp2_matmul #(.DATA_WIDTH(DATA_WIDTH)) u_sq (
      .clock (clock),
      .reset (reset),
      .start (step_start),
      .mat_a (base_ff),
      .mat_b (base_ff),
      .mat_c (sq_c),
      .done  (sq_done)
   );

   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      exp_in       = exp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      p00_in       = p00_ff;
      p01_in       = p01_ff;
      p10_in       = p10_ff;
      p11_in       = p11_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               // entries reduced to the working width, accumulator set to identity
               base_in[mp2_pkg::IDX_00] = DATA_WIDTH'($unsigned(req_m00));
               base_in[mp2_pkg::IDX_01] = DATA_WIDTH'($unsigned(req_m01));
               base_in[mp2_pkg::IDX_10] = DATA_WIDTH'($unsigned(req_m10));
               base_in[mp2_pkg::IDX_11] = DATA_WIDTH'($unsigned(req_m11));
               acc_in                   = '0;
               acc_in[mp2_pkg::IDX_00]  = DATA_WIDTH'(1);
               acc_in[mp2_pkg::IDX_11]  = DATA_WIDTH'(1);
               exp_in                   = req_exponent;
               state_in                 = S_STEP;
            end
         end
         S_STEP: begin
            // no set bits left: further squaring cannot change the result
            if (exp_ff == '0) begin
               state_in = S_FIN;
            end else begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (mul_done && sq_done) begin
               base_in = sq_c;
               if (exp_ff[0]) begin
                  acc_in = mul_c;
               end
               exp_in   = exp_ff >> 1;
               state_in = S_STEP;
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               p00_in       = $signed(FW'(acc_ff[mp2_pkg::IDX_00]));
               p01_in       = $signed(FW'(acc_ff[mp2_pkg::IDX_01]));
               p10_in       = $signed(FW'(acc_ff[mp2_pkg::IDX_10]));
               p11_in       = $signed(FW'(acc_ff[mp2_pkg::IDX_11]));
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      acc_ff  <= acc_in;
      exp_ff  <= exp_in;
      p00_ff  <= p00_in;
      p01_ff  <= p01_in;
      p10_ff  <= p10_in;
      p11_ff  <= p11_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // one item in flight: requests wait while the sequencer is busy
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_p00   = p00_ff;
   assign rsp_p01   = p01_ff;
   assign rsp_p10   = p10_ff;
   assign rsp_p11   = p11_ff;

endmodule

### rtl/core/mp2_matmul.sv
// ----------------------------------------------------------------------------
// mp2_matmul
// Digit-serial 2x2 matrix multiplier, c = a * b modulo 2^DATA_WIDTH.
// ----------------------------------------------------------------------------
module mp2_matmul #(
   parameter int DATA_WIDTH = mp2_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [3:0][DATA_WIDTH-1:0] mat_a,
   input  logic [3:0][DATA_WIDTH-1:0] mat_b,
   output logic [3:0][DATA_WIDTH-1:0] mat_c,
   output logic                       done
);

   localparam int D     = mp2_pkg::DIGIT_WIDTH;
   localparam int NDIG  = (DATA_WIDTH + D - 1) / D;
   localparam int CNT_W = $clog2(NDIG + 1);

   logic [3:0][DATA_WIDTH-1:0] a_ff, a_in;
   logic [3:0][DATA_WIDTH-1:0] b_ff, b_in;
   logic [3:0][DATA_WIDTH-1:0] c_ff, c_in;
   logic [3:0][DATA_WIDTH-1:0] pa, pb;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       done_ff, done_in;

   // a shifts left one digit per cycle, b hands out its low digit and shifts right
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      c_in    = c_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      pa      = '0;
      pb      = '0;
      if (start) begin
         a_in   = mat_a;
         b_in   = mat_b;
         c_in   = '0;
         cnt_in = CNT_W'(NDIG);
      end else if (cnt_ff != '0) begin
         for (int r = 0; r < 2; r++) begin
            for (int q = 0; q < 2; q++) begin
               pa[r*2+q]   = DATA_WIDTH'(a_ff[r*2] * b_ff[q][D-1:0]);
               pb[r*2+q]   = DATA_WIDTH'(a_ff[r*2+1] * b_ff[2+q][D-1:0]);
               c_in[r*2+q] = c_ff[r*2+q] + pa[r*2+q] + pb[r*2+q];
            end
         end
         for (int e = 0; e < 4; e++) begin
            a_in[e] = a_ff[e] << D;
            b_in[e] = b_ff[e] >> D;
         end
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign mat_c = c_ff;
   assign done  = done_ff;

endmodule

### rtl/core/mp2_checker.sv
// ----------------------------------------------------------------------------
// mp2_checker
// Port-level assertions for the 2x2 matrix power block, bound to its top.
// ----------------------------------------------------------------------------
module mp2_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input mp2_pkg::field_type req_m00,
   input mp2_pkg::field_type req_m01,
   input mp2_pkg::field_type req_m10,
   input mp2_pkg::field_type req_m11,
   input mp2_pkg::exp_type   req_exponent,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input mp2_pkg::field_type rsp_p00,
   input mp2_pkg::field_type rsp_p01,
   input mp2_pkg::field_type rsp_p10,
   input mp2_pkg::field_type rsp_p11
);

   // stalled request holds until its transfer
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_m00) && $stable(req_m01)
         && $stable(req_m10) && $stable(req_m11) && $stable(req_exponent))
      else $error("stalled request changed");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_p00) && $stable(rsp_p01)
         && $stable(rsp_p10) && $stable(rsp_p11))
      else $error("stalled result changed");

   // one item at a time: a request transfer closes the input
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input open right after a transfer");

   // a new result appears exactly when the block frees up for the next item
   a_rsp_with_free: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $fell(req_stall))
      else $error("result appeared while block still busy");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind matrix_power_2x2 mp2_checker u_mp2_checker (.*);
